// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;
  localparam int HEAP_BYTES   = 65536;
  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;
  localparam int SPLIT_MIN    = 8;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int LINK_W       = IDX_W + 1;
  localparam int OFF_W        = 16;
  localparam int LEN_W        = 17;
  localparam int SIZE_W       = 18;
  localparam int BRK_W        = 17;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic              free;
    logic [LINK_W-1:0] link;
  } seg_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_NO_SPACE = 3'd2,
    STS_FULL     = 3'd3,
    STS_NOT_FND  = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } act_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_FIX,
    FSM_APPEND,
    FSM_APP_LNK,
    FSM_MRG,
    FSM_MOVE,
    FSM_SWEEP
  } fsm_t;

  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] addr;
    status_t          status;
  } res_t;
endpackage

// ===== rtl/ffha_seg_ram.sv =====
module ffha_seg_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ffha_pkg::IDX_W-1:0] wr_addr,
  input  ffha_pkg::seg_t            wr_data,
  input  logic                      rd_en,
  input  logic [ffha_pkg::IDX_W-1:0] rd_addr,
  output ffha_pkg::seg_t            rd_data
);
  import ffha_pkg::*;

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_action,
  input  logic [16:0]                 in_req_size,
  input  logic [15:0]                 in_address,
  output logic                        busy,
  output logic                        wr_en,
  output logic [ffha_pkg::IDX_W-1:0]  wr_addr,
  output ffha_pkg::seg_t              wr_data,
  output logic                        rd_en,
  output logic [ffha_pkg::IDX_W-1:0]  rd_addr,
  input  ffha_pkg::seg_t              rd_data,
  output ffha_pkg::res_t              res
);
  import ffha_pkg::*;

  fsm_t               state_r, state_nxt;
  logic               act_r, act_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [OFF_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   nx_r, nx_nxt;
  seg_t               ent_r, ent_nxt;
  logic [LINK_W-1:0]  cnt_r, cnt_nxt;
  logic [BRK_W-1:0]   brk_r, brk_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [LINK_W-1:0]  sw_r, sw_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;

  seg_t               e;
  seg_t               mv_src;
  logic [SIZE_W-1:0]  in_size_rnd;
  logic [SIZE_W-1:0]  rem;
  logic               alloc_hit, can_split, free_hit, end_link, nx_ok;
  logic [SIZE_W:0]    need;
  logic [SIZE_W-1:0]  room;
  logic               fits;
  logic [LINK_W-1:0]  last;
  logic [LEN_W-1:0]   mrg_len;
  logic               sweep_done;

  assign e           = rd_data;
  assign in_size_rnd = ({1'b0, in_req_size} + SIZE_W'(ALIGN_BYTES - 1))
                       & ~SIZE_W'(ALIGN_BYTES - 1);
  assign alloc_hit   = e.free && ({1'b0, e.len} >= size_r);
  assign rem         = {1'b0, e.len} - size_r;
  assign can_split   = (rem >= SIZE_W'(HEADER_BYTES + SPLIT_MIN)) && !cnt_r[IDX_W];
  assign free_hit    = ({1'b0, e.off} + 17'(HEADER_BYTES)) == {1'b0, addr_r};
  assign end_link    = e.link[IDX_W];
  assign nx_ok       = !e.link[IDX_W] && (e.link < cnt_r) && (e.link[IDX_W-1:0] != cur_r);
  assign need        = (SIZE_W+1)'(HEADER_BYTES) + {1'b0, size_r};
  assign room        = SIZE_W'(HEAP_BYTES) - {1'b0, brk_r};
  assign fits        = need <= {1'b0, room};
  assign last        = cnt_r - LINK_W'(1);
  assign mrg_len     = LEN_W'({1'b0, ent_r.len} + 18'(HEADER_BYTES) + {1'b0, e.len});
  assign mv_src      = (cur_r == last[IDX_W-1:0]) ? ent_r : e;
  assign sweep_done  = (sw_r == last) && !chk_vld_r;
  assign busy        = (state_r != FSM_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FSM_IDLE;
      cnt_r     <= '0;
      brk_r     <= '0;
      tail_r    <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      brk_r     <= brk_nxt;
      tail_r    <= tail_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    ent_r     <= ent_nxt;
    sw_r      <= sw_nxt;
    chk_idx_r <= chk_idx_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          if (in_action == ACT_ALLOC) begin
            if (in_req_size == '0)     state_nxt = FSM_IDLE;
            else if (cnt_r == '0)      state_nxt = FSM_APPEND;
            else                       state_nxt = FSM_WALK;
          end else begin
            if (in_address == '0 || cnt_r == '0) state_nxt = FSM_IDLE;
            else                                 state_nxt = FSM_WALK;
          end
        end
      end
      FSM_WALK: begin
        if (act_r == ACT_ALLOC) begin
          if (alloc_hit)     state_nxt = can_split ? FSM_FIX : FSM_IDLE;
          else if (end_link) state_nxt = FSM_APPEND;
        end else begin
          if (free_hit)      state_nxt = nx_ok ? FSM_MRG : FSM_IDLE;
          else if (end_link) state_nxt = FSM_IDLE;
        end
      end
      FSM_FIX:     state_nxt = FSM_IDLE;
      FSM_APPEND: begin
        if (cnt_r[IDX_W] || !fits || cnt_r == '0) state_nxt = FSM_IDLE;
        else                                      state_nxt = FSM_APP_LNK;
      end
      FSM_APP_LNK: state_nxt = FSM_IDLE;
      FSM_MRG: begin
        if (e.free && ({1'b0, nx_r} != last)) state_nxt = FSM_MOVE;
        else                                  state_nxt = FSM_IDLE;
      end
      FSM_MOVE:    state_nxt = FSM_SWEEP;
      FSM_SWEEP:   if (sweep_done) state_nxt = FSM_IDLE;
      default:     state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, memory ports and result
  always_comb begin
    act_nxt     = act_r;
    size_nxt    = size_r;
    addr_nxt    = addr_r;
    cur_nxt     = cur_r;
    nx_nxt      = nx_r;
    ent_nxt     = ent_r;
    cnt_nxt     = cnt_r;
    brk_nxt     = brk_r;
    tail_nxt    = tail_r;
    sw_nxt      = sw_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    wr_en       = 1'b0;
    wr_addr     = cur_r;
    wr_data     = e;
    rd_en       = 1'b0;
    rd_addr     = '0;
    res.vld     = 1'b0;
    res.addr    = '0;
    res.status  = STS_OK;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          size_nxt = in_size_rnd;
          addr_nxt = in_address;
          cur_nxt  = '0;
          rd_en    = 1'b1;
          if (in_action == ACT_ALLOC && in_req_size == '0) begin
            res.vld    = 1'b1;
            res.status = STS_ZERO;
          end else if (in_action == ACT_FREE && in_address == '0) begin
            res.vld    = 1'b1;
            res.status = STS_ZERO;
          end else if (in_action == ACT_FREE && cnt_r == '0) begin
            res.vld    = 1'b1;
            res.status = STS_NOT_FND;
          end
        end
      end
      FSM_WALK: begin
        ent_nxt = e;
        if (act_r == ACT_ALLOC) begin
          if (alloc_hit) begin
            if (can_split) begin
              // split off the tail as a new free segment in the next slot
              wr_en         = 1'b1;
              wr_addr       = cnt_r[IDX_W-1:0];
              wr_data.off   = OFF_W'({1'b0, e.off} + 17'(HEADER_BYTES) + size_r[16:0]);
              wr_data.len   = LEN_W'(rem - SIZE_W'(HEADER_BYTES));
              wr_data.free  = 1'b1;
              wr_data.link  = e.link;
              if (tail_r == cur_r) tail_nxt = cnt_r[IDX_W-1:0];
              cnt_nxt       = cnt_r + LINK_W'(1);
            end else begin
              wr_en        = 1'b1;
              wr_data.free = 1'b0;
              res.vld      = 1'b1;
              res.addr     = e.off + OFF_W'(HEADER_BYTES);
            end
          end else if (!end_link) begin
            rd_en   = 1'b1;
            rd_addr = e.link[IDX_W-1:0];
            cur_nxt = e.link[IDX_W-1:0];
          end
        end else begin
          if (free_hit) begin
            wr_en        = 1'b1;
            wr_data.free = 1'b1;
            ent_nxt.free = 1'b1;
            nx_nxt       = e.link[IDX_W-1:0];
            if (nx_ok) begin
              rd_en   = 1'b1;
              rd_addr = e.link[IDX_W-1:0];
            end else begin
              res.vld = 1'b1;
            end
          end else if (end_link) begin
            res.vld    = 1'b1;
            res.status = STS_NOT_FND;
          end else begin
            rd_en   = 1'b1;
            rd_addr = e.link[IDX_W-1:0];
            cur_nxt = e.link[IDX_W-1:0];
          end
        end
      end
      FSM_FIX: begin
        wr_en        = 1'b1;
        wr_data      = ent_r;
        wr_data.len  = size_r[LEN_W-1:0];
        wr_data.free = 1'b0;
        wr_data.link = cnt_r - LINK_W'(1);
        res.vld      = 1'b1;
        res.addr     = ent_r.off + OFF_W'(HEADER_BYTES);
      end
      FSM_APPEND: begin
        if (cnt_r[IDX_W]) begin
          res.vld    = 1'b1;
          res.status = STS_FULL;
        end else if (!fits) begin
          res.vld    = 1'b1;
          res.status = STS_NO_SPACE;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = cnt_r[IDX_W-1:0];
          wr_data.off  = brk_r[OFF_W-1:0];
          wr_data.len  = size_r[LEN_W-1:0];
          wr_data.free = 1'b0;
          wr_data.link = LINK_W'(MAX_SEGMENTS);
          ent_nxt      = wr_data;
          brk_nxt      = BRK_W'({1'b0, brk_r} + need[BRK_W:0]);
          cnt_nxt      = cnt_r + LINK_W'(1);
          tail_nxt     = cnt_r[IDX_W-1:0];
          cur_nxt      = tail_r;
          nx_nxt       = cnt_r[IDX_W-1:0];
          if (cnt_r == '0) begin
            res.vld  = 1'b1;
            res.addr = brk_r[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
          end else begin
            rd_en   = 1'b1;
            rd_addr = tail_r;
          end
        end
      end
      FSM_APP_LNK: begin
        // link the old tail to the new segment
        wr_en        = 1'b1;
        wr_data      = e;
        wr_data.link = {1'b0, nx_r};
        res.vld      = 1'b1;
        res.addr     = ent_r.off + OFF_W'(HEADER_BYTES);
      end
      FSM_MRG: begin
        if (e.free) begin
          wr_en        = 1'b1;
          wr_data      = ent_r;
          wr_data.len  = mrg_len;
          wr_data.link = e.link;
          ent_nxt      = wr_data;
          if (tail_r == nx_r) tail_nxt = cur_r;
          if ({1'b0, nx_r} == last) begin
            cnt_nxt = last;
            res.vld = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = last[IDX_W-1:0];
          end
        end else begin
          res.vld = 1'b1;
        end
      end
      FSM_MOVE: begin
        // move the last slot into the released one; forward the merged
        // entry when it was the last slot itself
        wr_en   = 1'b1;
        wr_addr = nx_r;
        wr_data = mv_src;
        if (tail_r == last[IDX_W-1:0]) tail_nxt = nx_r;
        sw_nxt  = '0;
      end
      FSM_SWEEP: begin
        if (sw_r != last) begin
          rd_en       = 1'b1;
          rd_addr     = sw_r[IDX_W-1:0];
          sw_nxt      = sw_r + LINK_W'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = sw_r[IDX_W-1:0];
        end
        if (chk_vld_r && e.link == last) begin
          wr_en        = 1'b1;
          wr_addr      = chk_idx_r;
          wr_data      = e;
          wr_data.link = {1'b0, nx_r};
        end
        if (sweep_done) begin
          cnt_nxt = last;
          res.vld = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Zero-size, null and empty-table free requests finish straight from idle; others walk
// the segment list, then split or append where needed, and a merge that frees a slot
// also moves the last slot into it and sweeps the table to relink it.
// Throughput: one transaction at a time, set by the list walk (one segment per
// cycle) and the relink sweep.
// Reset: synchronous active-low rst_n clears count, break and tail; table is unset.
`include "assert_macros.svh"

module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [16:0] in_req_size,
  input  logic [15:0] in_address,
  output logic        out_valid,
  output logic [15:0] out_payload_addr,
  output logic [2:0]  out_status
);
  import ffha_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  seg_t             wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  seg_t             rd_data;
  res_t             res;
  logic             out_valid_r;
  logic [15:0]      out_addr_r;
  logic [2:0]       out_status_r;

  // Segment table: offset, length, free flag and link packed per entry
  ffha_seg_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: walks the list, splits, appends and merges
  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_action   (in_action),
    .in_req_size (in_req_size),
    .in_address  (in_address),
    .busy        (busy),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res         (res)
  );

  // Register the result: strobe for one cycle, receiver cannot stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_addr_r   <= res.addr;
      out_status_r <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_addr = out_addr_r;
  assign out_status       = out_status_r;

  // An accepted transaction either finishes at once or keeps the block busy
  `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid)
  // A failed transaction never reports an address
  `ASSERT_IMPL(a_fail_no_addr, clk, rst_n, out_valid && out_status != STS_OK, out_payload_addr == '0)
  // A result ends the transaction: the block is free again unless a new start was taken
  `ASSERT_IMPL(a_result_idle, clk, rst_n, out_valid, !busy || $past(start))
endmodule
